// File: rtl/hwheel_pkg.sv
// Types and constants for the hashed timer wheel.
// No dependencies; imported by hashed_timer_wheel_top.
package hwheel_pkg;

    localparam int ID_W    = 5;
    localparam int DELAY_W = 20;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2
    } req_code_t;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay_ticks;
    } req_t;

    typedef struct packed {
        logic            status;
        logic            expired_valid;
        logic [ID_W-1:0] expired_id;
        logic            last;
    } rsp_t;

endpackage

// File: rtl/hashed_timer_wheel_top.sv
// Hashed timing wheel with rounds over a fixed table of timers indexed by id.
// Depends on hwheel_pkg for the word types and request codes.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid, req_stall | req_word (req_t)
//   rsp     | out       | rsp_valid, rsp_stall | rsp_word (rsp_t)
//
// Start, cancel and unused codes give one word each.
// A tick walks the timer table through one shared slot/rounds memory port:
// an idle entry passes through ST_READ alone, a live entry through ST_READ and
// ST_EVAL, then ST_CLOSE ends it; ST_EVAL and ST_CLOSE can wait on rsp_stall.
// Reset clears the valid marks, the slot pointer and the control state.
// No request is taken while a tick walks or while a response word is stalled.
module hashed_timer_wheel_top
    import hwheel_pkg::*;
#(
    parameter int WHEEL_SLOTS = 16,
    parameter int MAX_TIMERS  = 32,
    parameter int ROUND_BITS  = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_word,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_word
);

    localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int ENT_W  = SLOT_W + ROUND_BITS;
    localparam logic [32:0] ROUND_MAX = (33'd1 << ROUND_BITS) - 33'd1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TIMERS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_CLOSE
    } state_t;

    state_t              state_reg, state_next;
    logic [MAX_TIMERS-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_id_reg, pend_id_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_word_reg, rsp_word_next;

    logic [ENT_W-1:0]    mem [MAX_TIMERS];
    logic [ENT_W-1:0]    rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENT_W-1:0]    mem_wdata;

    logic                out_free;
    logic                id_in_range;
    logic [IDX_W-1:0]    req_idx;
    logic [32:0]         rounds_wide;
    logic [ROUND_BITS-1:0] rounds_sat;
    logic [SLOT_W-1:0]   start_slot;
    logic [SLOT_W-1:0]   rd_slot;
    logic [ROUND_BITS-1:0] rd_rounds;

    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign req_stall   = !((state_reg == ST_IDLE) && out_free);
    assign rsp_valid   = rsp_valid_reg;
    assign rsp_word    = rsp_word_reg;

    assign id_in_range = 32'(req_word.timer_id) < MAX_TIMERS;
    assign req_idx     = IDX_W'(req_word.timer_id);
    assign rounds_wide = 33'(req_word.delay_ticks >> SLOT_W);
    assign rounds_sat  = (rounds_wide > ROUND_MAX) ? ROUND_MAX[ROUND_BITS-1:0]
                                                   : rounds_wide[ROUND_BITS-1:0];
    assign start_slot  = cur_slot_reg + req_word.delay_ticks[SLOT_W-1:0];
    assign rd_slot     = rd_data_reg[ROUND_BITS +: SLOT_W];
    assign rd_rounds   = rd_data_reg[ROUND_BITS-1:0];

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cur_slot_next   = cur_slot_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_word_next   = rsp_word_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = req_idx;
        mem_wdata       = {start_slot, rounds_sat};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && out_free)
                begin
                    rsp_word_next = '{status: STATUS_OK, expired_valid: 1'b0,
                                      expired_id: '0, last: 1'b1};
                    unique case (req_word.req_type)
                        REQ_START:
                        begin
                            rsp_valid_next = 1'b1;
                            if (id_in_range)
                            begin
                                mem_we              = 1'b1;
                                valid_next[req_idx] = 1'b1;
                            end
                        end
                        REQ_CANCEL:
                        begin
                            rsp_valid_next = 1'b1;
                            if (id_in_range && valid_reg[req_idx])
                            begin
                                valid_next[req_idx] = 1'b0;
                            end
                            else
                            begin
                                rsp_word_next.status = STATUS_NOT_FOUND;
                            end
                        end
                        REQ_TICK:
                        begin
                            scan_idx_next   = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_READ;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (valid_reg[scan_idx_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = ST_EVAL;
                end
                else if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_EVAL:
            begin
                if (!(rd_slot == cur_slot_reg && rd_rounds == '0 && pend_valid_reg
                      && !out_free))
                begin
                    if (rd_slot == cur_slot_reg)
                    begin
                        if (rd_rounds == '0)
                        begin
                            valid_next[scan_idx_reg] = 1'b0;
                            if (pend_valid_reg)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_word_next  = '{status: STATUS_OK, expired_valid: 1'b1,
                                                   expired_id: ID_W'(pend_id_reg),
                                                   last: 1'b0};
                            end
                            pend_valid_next = 1'b1;
                            pend_id_next    = scan_idx_reg;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = scan_idx_reg;
                            mem_wdata = {rd_slot, rd_rounds - 1'b1};
                        end
                    end
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_CLOSE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_CLOSE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = '{status: STATUS_OK, expired_valid: pend_valid_reg,
                                       expired_id: pend_valid_reg ? ID_W'(pend_id_reg)
                                                                  : ID_W'(0),
                                       last: 1'b1};
                    cur_slot_next  = cur_slot_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            cur_slot_reg   <= '0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cur_slot_reg   <= cur_slot_next;
            scan_idx_reg   <= scan_idx_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg  <= pend_id_next;
        rsp_word_reg <= rsp_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

endmodule

// File: tb/sv/hwheel_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for hashed_timer_wheel_top: watches both channels, models the wheel
// and checks every response word against the modeled one.
// Depends on hwheel_pkg for the word types and request codes.
module hwheel_scoreboard
    import hwheel_pkg::*;
#(
    parameter int WHEEL_SLOTS = 16,
    parameter int MAX_TIMERS  = 32,
    parameter int ROUND_BITS  = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req_word,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp_word,
    output int   fail_count,
    output int   pending
);

    localparam int     SLOT_W    = $clog2(WHEEL_SLOTS);
    localparam longint ROUND_MAX = (longint'(1) << ROUND_BITS) - 1;

    logic                  live      [MAX_TIMERS];
    logic [SLOT_W-1:0]     home_slot [MAX_TIMERS];
    logic [ROUND_BITS-1:0] laps_left [MAX_TIMERS];
    logic [SLOT_W-1:0]     hand;
    rsp_t                  rsp_due   [$];

    task automatic queue_word(input rsp_t w);
        rsp_due = {rsp_due, w};
    endtask

    task automatic take_request(input req_t w);
        longint laps;
        rsp_t   word;
        int     fired [$];
        word      = '0;
        word.last = 1'b1;
        case (w.req_type)
            REQ_START:
            begin
                if (int'(w.timer_id) < MAX_TIMERS)
                begin
                    laps = longint'(w.delay_ticks) / WHEEL_SLOTS;
                    if (laps > ROUND_MAX)
                        laps = ROUND_MAX;
                    live[w.timer_id]      = 1'b1;
                    home_slot[w.timer_id] =
                        SLOT_W'((longint'(hand) + longint'(w.delay_ticks)) % WHEEL_SLOTS);
                    laps_left[w.timer_id] = ROUND_BITS'(laps);
                end
                queue_word(word);
            end
            REQ_CANCEL:
            begin
                word.status = STATUS_NOT_FOUND;
                if (int'(w.timer_id) < MAX_TIMERS && live[w.timer_id])
                begin
                    live[w.timer_id] = 1'b0;
                    word.status      = STATUS_OK;
                end
                queue_word(word);
            end
            REQ_TICK:
            begin
                for (int i = 0; i < MAX_TIMERS; i++)
                begin
                    if (live[i] && home_slot[i] == hand)
                    begin
                        if (laps_left[i] == '0)
                        begin
                            live[i] = 1'b0;
                            fired   = {fired, i};
                        end
                        else
                        begin
                            laps_left[i] = laps_left[i] - 1'b1;
                        end
                    end
                end
                hand = SLOT_W'((int'(hand) + 1) % WHEEL_SLOTS);
                if (fired.size() == 0)
                    queue_word(word);
                else
                    foreach (fired[k])
                        queue_word(rsp_t'{status: STATUS_OK,
                                          expired_valid: 1'b1,
                                          expired_id: ID_W'(fired[k]),
                                          last: (k == fired.size() - 1)});
            end
            default:
            begin
                queue_word(word);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            foreach (live[i])
                live[i] = 1'b0;
            hand = '0;
            rsp_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                take_request(req_word);
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("unexpected response word %p", rsp_word);
                    fail_count++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp_word.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                        fail_count++;
                    end
                    if (rsp_word.expired_valid !== want.expired_valid)
                    begin
                        $error("expired_valid: expected %0d, got %0d",
                               want.expired_valid, rsp_word.expired_valid);
                        fail_count++;
                    end
                    if (rsp_word.expired_id !== want.expired_id)
                    begin
                        $error("expired_id: expected %0d, got %0d",
                               want.expired_id, rsp_word.expired_id);
                        fail_count++;
                    end
                    if (rsp_word.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp_word.last);
                        fail_count++;
                    end
                end
            end
            pending = rsp_due.size();
        end
    end

endmodule

// File: tb/sv/hashed_timer_wheel_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for hashed_timer_wheel_top: drives request words and response
// stalls, and gives the verdict. Depends on hwheel_pkg and hwheel_scoreboard.
module hashed_timer_wheel_top_tb
    import hwheel_pkg::*;
();

    localparam int         WHEEL_SLOTS   = 16;
    localparam int         MAX_TIMERS    = 32;
    localparam int         ROUND_BITS    = 16;
    localparam int         PHASES        = 4;
    localparam int         PHASE_WORDS   = 36;
    localparam int         SETTLE_CYCLES = 2 * MAX_TIMERS + 16;
    localparam int         CYCLE_LIMIT   = 600000;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_word;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_word;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   steady = 1'b0;

    hashed_timer_wheel_top #(
        .WHEEL_SLOTS(WHEEL_SLOTS),
        .MAX_TIMERS (MAX_TIMERS),
        .ROUND_BITS (ROUND_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word (req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word (rsp_word)
    );

    hwheel_scoreboard #(
        .WHEEL_SLOTS(WHEEL_SLOTS),
        .MAX_TIMERS (MAX_TIMERS),
        .ROUND_BITS (ROUND_BITS)
    ) u_scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_req(input logic [1:0] kind, input logic [ID_W-1:0] id,
                            input logic [DELAY_W-1:0] delay);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= req_t'{req_type: kind, timer_id: id, delay_ticks: delay};
        do @(posedge clk); while (req_stall);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int hold;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin
        int                 pick;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]    id;
        req_valid <= 1'b0;
        req_word  <= '0;
        rst_n     <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(REQ_START, 5'd0, 20'd0);
        send_req(REQ_START, 5'd20, 20'd0);
        send_req(REQ_START, 5'd12, 20'd16);
        send_req(REQ_START, 5'd31, 20'hFFFFF);
        send_req(REQ_START, 5'd5, 20'd3);
        send_req(REQ_START, 5'd5, 20'd1);
        send_req(REQ_CANCEL, 5'd7, 20'hFFFFF);
        send_req(REQ_START, 5'd7, 20'd2);
        send_req(REQ_CANCEL, 5'd7, 20'd0);
        send_req(REQ_UNUSED, 5'd31, 20'hFFFFF);
        repeat (15)
            send_req(REQ_TICK, 5'd0, 20'd0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            steady = (phase == 1);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick  = $urandom_range(0, 99);
                id    = ID_W'($urandom_range(0, 31));
                delay = ($urandom_range(0, 7) == 0) ? DELAY_W'($urandom)
                                                    : DELAY_W'($urandom_range(0, 3 * WHEEL_SLOTS));
                if (pick < 40)
                    send_req(REQ_START, id, delay);
                else if (pick < 60)
                    send_req(REQ_CANCEL, id, DELAY_W'($urandom));
                else if (pick < 95)
                    send_req(REQ_TICK, id, DELAY_W'($urandom));
                else
                    send_req(REQ_UNUSED, id, DELAY_W'($urandom));
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/hwheel_pkg.sv
rtl/hashed_timer_wheel_top.sv
tb/sv/hwheel_scoreboard.sv
tb/sv/hashed_timer_wheel_top_tb.sv
